/* rtl/core/pcxrle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int DATA_W  = 8;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 18;
    localparam int BPL_W   = 16;
    localparam int PC_W    = 3;
    localparam int CNT_W   = 6;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [DATA_W-1:0] COUNT_MASK = 8'hC0;

    typedef enum logic [1:0] {
        REG_RLE_ENABLED    = 2'd0,
        REG_BYTES_PER_LINE = 2'd1,
        REG_PLANE_COUNT    = 2'd2,
        REG_IMAGE_ROWS     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic             rle_enabled;
        logic [BPL_W-1:0] bytes_per_line;
        logic [PC_W-1:0]  plane_count;
        logic [ROW_W-1:0] image_rows;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load_run;
        logic load_count;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic value_expected;
        logic count_byte;
        logic count_zero;
        logic out_free;
        logic last;
        logic line_end;
    } dp_status_t;

endpackage

/* rtl/core/pcx_rle_scanline_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// PCX run-length decoder giving each byte with its row and interleaved column.
// ----------------------------------------------------------------------------
// a taken literal or value loads the run registers before its results are emitted
// throughput: one result word per cycle from a single emit stage while the
//   output is free; a run is taken as count, value, then its n results
// the next word is taken with the last result of a run unless it ends a line
// reset: synchronous active low; position, run state and registers to defaults
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder import pcxrle_pkg::*; #(
    parameter int MAX_PLANES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DATA_W-1:0]  s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ROW_W-1:0]   m_row,
    output logic [COL_W-1:0]   m_column,
    output logic [DATA_W-1:0]  m_pixel_byte,
    output logic               m_run_last,
    output logic               m_image_last
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t sts;

    pcxrle_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcxrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcxrle_dp #(
        .MAX_PLANES (MAX_PLANES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .s_data_byte  (s_data_byte),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row        (m_row),
        .m_column     (m_column),
        .m_pixel_byte (m_pixel_byte),
        .m_run_last   (m_run_last),
        .m_image_last (m_image_last)
    );

    // nothing follows the final word of the image
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_image_last) |=> !m_valid)
        else $error("word after end of image");

    // no new word while a run still has results to give
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !sts.last) |-> !s_ready)
        else $error("input taken in the middle of a run");

    // end of image always closes the run
    a_img_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_image_last) |-> m_run_last)
        else $error("end of image without run end");

    // rows stay inside the image
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_row < cfg.image_rows))
        else $error("row beyond image");

endmodule

/* rtl/core/pcxrle_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_regs
// APB-style configuration registers of the decoder.
// ----------------------------------------------------------------------------
module pcxrle_regs import pcxrle_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rle_enabled    <= 1'b1;
            cfg_reg.bytes_per_line <= BPL_W'(1);
            cfg_reg.plane_count    <= PC_W'(1);
            cfg_reg.image_rows     <= ROW_W'(1);
        end else if (wr_en) begin
            unique case (index)
                REG_RLE_ENABLED:    cfg_reg.rle_enabled    <= pwdata[0];
                REG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= pwdata[BPL_W-1:0];
                REG_PLANE_COUNT:    cfg_reg.plane_count    <= pwdata[PC_W-1:0];
                REG_IMAGE_ROWS:     cfg_reg.image_rows     <= pwdata[ROW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_RLE_ENABLED:    prdata = PDATA_W'(cfg_reg.rle_enabled);
            REG_BYTES_PER_LINE: prdata = PDATA_W'(cfg_reg.bytes_per_line);
            REG_PLANE_COUNT:    prdata = PDATA_W'(cfg_reg.plane_count);
            REG_IMAGE_ROWS:     prdata = PDATA_W'(cfg_reg.image_rows);
        endcase
    end

endmodule

/* rtl/core/pcxrle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Controller: takes input words, decodes count/value/literal, sequences runs.
// ----------------------------------------------------------------------------
module pcxrle_ctrl import pcxrle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_RUN: begin
                cmd.emit = sts.out_free;
                // next word may enter with the last result unless a line ends
                s_ready  = sts.out_free && sts.last && !sts.line_end;
                if (sts.out_free && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
        if (s_valid && s_ready && !sts.dead) begin
            priority if (sts.value_expected) begin
                cmd.load_run = 1'b1;
                if (!sts.count_zero) begin
                    state_next = ST_RUN;
                end
            end else if (sts.count_byte) begin
                cmd.load_count = 1'b1;
            end else begin
                cmd.load_run = 1'b1;
                state_next   = ST_RUN;
            end
        end
    end

endmodule

/* rtl/core/pcxrle_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: run state, scanline position and the output register.
// ----------------------------------------------------------------------------
module pcxrle_dp import pcxrle_pkg::*; #(
    parameter int MAX_PLANES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    input  logic [DATA_W-1:0] s_data_byte,
    output dp_status_t        sts,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROW_W-1:0]  m_row,
    output logic [COL_W-1:0]  m_column,
    output logic [DATA_W-1:0] m_pixel_byte,
    output logic              m_run_last,
    output logic              m_image_last
);

    localparam int PI_W   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PN_W   = $clog2(MAX_PLANES + 1);
    localparam int PROD_W = (BPL_W + PN_W + 1 > COL_W) ? BPL_W + PN_W + 1 : COL_W;

    logic              value_expected_reg;
    logic [CNT_W-1:0]  run_count_reg;
    logic [CNT_W-1:0]  remain_reg;
    logic [DATA_W-1:0] pixel_reg;
    logic [PI_W-1:0]   plane_index_reg;
    logic [BPL_W-1:0]  plane_byte_reg;
    logic [ROW_W-1:0]  row_index_reg;
    logic              finished_reg;
    logic              m_valid_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [COL_W-1:0]  m_column_reg;
    logic [DATA_W-1:0] m_pixel_byte_reg;
    logic              m_run_last_reg;
    logic              m_image_last_reg;

    logic [3:0]        pc_ext;
    logic [PN_W-1:0]   planes_eff;
    logic [BPL_W-1:0]  bpl_eff;
    logic [BPL_W:0]    pb_inc;
    logic [PN_W-1:0]   pi_inc;
    logic [ROW_W:0]    row_inc;
    logic              plane_end;
    logic              planes_end;
    logic              line_end;
    logic              img_end;
    logic              last;
    logic [PROD_W-1:0] col_full;

    always_comb begin
        pc_ext = 4'(cfg.plane_count);
        priority if (pc_ext == 4'd0) begin
            planes_eff = PN_W'(1);
        end else if (pc_ext > 4'(MAX_PLANES)) begin
            planes_eff = PN_W'(MAX_PLANES);
        end else begin
            planes_eff = PN_W'(pc_ext);
        end
    end

    assign bpl_eff    = (cfg.bytes_per_line == '0) ? BPL_W'(1) : cfg.bytes_per_line;
    assign pb_inc     = {1'b0, plane_byte_reg} + (BPL_W+1)'(1);
    assign pi_inc     = PN_W'(plane_index_reg) + PN_W'(1);
    assign row_inc    = {1'b0, row_index_reg} + (ROW_W+1)'(1);
    assign plane_end  = pb_inc >= {1'b0, bpl_eff};
    assign planes_end = pi_inc >= planes_eff;
    assign line_end   = plane_end && planes_end;
    assign img_end    = line_end && (row_inc >= {1'b0, cfg.image_rows});
    assign last       = (remain_reg == CNT_W'(1)) || line_end;
    assign col_full   = PROD_W'(plane_byte_reg) * PROD_W'(planes_eff)
                      + PROD_W'(plane_index_reg);

    assign sts.dead           = finished_reg || (row_index_reg >= cfg.image_rows);
    assign sts.value_expected = value_expected_reg;
    assign sts.count_byte     = cfg.rle_enabled
                              && ((s_data_byte & COUNT_MASK) == COUNT_MASK);
    assign sts.count_zero     = (run_count_reg == '0);
    assign sts.out_free       = !m_valid_reg || m_ready;
    assign sts.last           = last;
    assign sts.line_end       = line_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_expected_reg <= 1'b0;
            run_count_reg      <= '0;
            plane_index_reg    <= '0;
            plane_byte_reg     <= '0;
            row_index_reg      <= '0;
            finished_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cmd.emit) begin
                if (plane_end) begin
                    plane_byte_reg <= '0;
                    if (planes_end) begin
                        plane_index_reg <= '0;
                        row_index_reg   <= row_inc[ROW_W-1:0];
                        if (img_end) begin
                            finished_reg <= 1'b1;
                        end
                    end else begin
                        plane_index_reg <= pi_inc[PI_W-1:0];
                    end
                end else begin
                    plane_byte_reg <= pb_inc[BPL_W-1:0];
                end
            end
            if (cmd.load_run) begin
                value_expected_reg <= 1'b0;
            end
            if (cmd.load_count) begin
                run_count_reg      <= s_data_byte[CNT_W-1:0];
                value_expected_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_row_reg        <= row_index_reg;
            m_column_reg     <= col_full[COL_W-1:0];
            m_pixel_byte_reg <= pixel_reg;
            m_run_last_reg   <= last;
            m_image_last_reg <= img_end;
        end
        if (cmd.load_run) begin
            remain_reg <= value_expected_reg ? run_count_reg : CNT_W'(1);
            pixel_reg  <= s_data_byte;
        end else if (cmd.emit) begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row        = m_row_reg;
    assign m_column     = m_column_reg;
    assign m_pixel_byte = m_pixel_byte_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_image_last = m_image_last_reg;

endmodule

/* sim/tb_pcx_rle_scanline_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcx_rle_scanline_decoder
// Self-checking bench for the PCX run-length scanline decoder. A directed
// table covers literals, runs, zero counts, run cut-off at line end, RLE off,
// clamped plane and line settings and rows past the image. Random phases
// follow, and the image is finished at the end. Every decoded word is checked
// against a table entry or a cycle-free decoder model of row, plane and column.
// ----------------------------------------------------------------------------
module tb_pcx_rle_scanline_decoder;
    import pcxrle_pkg::*;

    localparam int MAX_PLANES = 4;
    localparam int SETTLE     = 8;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [DATA_W-1:0] pixel;
        logic              run_last;
        logic              image_last;
    } pix_t;

    typedef enum logic {
        STEP_REG,
        STEP_BYTE
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        reg_index_t  idx;
        logic [31:0] val;
        bit          typed;
        pix_t        want;
    } step_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [DATA_W-1:0]  s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic [ROW_W-1:0]   m_row;
    logic [COL_W-1:0]   m_column;
    logic [DATA_W-1:0]  m_pixel_byte;
    logic               m_run_last;
    logic               m_image_last;

    // decoder model state
    bit               cfg_rle    = 1'b1;
    bit [BPL_W-1:0]   cfg_bpl    = 1;
    bit [PC_W-1:0]    cfg_planes = 1;
    bit [ROW_W-1:0]   cfg_rows   = 1;
    bit               value_due  = 1'b0;
    bit [CNT_W-1:0]   run_len    = '0;
    bit [1:0]         pos_plane  = '0;
    bit [BPL_W-1:0]   pos_byte   = '0;
    bit [ROW_W-1:0]   pos_row    = '0;
    bit               image_done = 1'b0;

    pix_t   decoded[$];
    pix_t   pixels_due[$];
    pix_t   head;
    step_t  plan[$];
    int     mismatches = 0;
    int     burst_left = 0;
    int     ready_tick = 0;
    int     ready_mode = 0;

    pcx_rle_scanline_decoder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row        (m_row),
        .m_column     (m_column),
        .m_pixel_byte (m_pixel_byte),
        .m_run_last   (m_run_last),
        .m_image_last (m_image_last)
    );

    always #6 aclk = ~aclk;

    function automatic step_t reg_step(input reg_index_t idx, input logic [31:0] val);
        step_t s;
        s = '{kind: STEP_REG, idx: idx, val: val, typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic step_t byte_step(input logic [DATA_W-1:0] b);
        step_t s;
        s = '{kind: STEP_BYTE, idx: REG_RLE_ENABLED, val: 32'(b), typed: 1'b0, want: '0};
        return s;
    endfunction

    // one word expected at column 0 of the given row
    function automatic step_t pix_step(input logic [DATA_W-1:0] b, input int row);
        step_t s;
        s = byte_step(b);
        s.typed = 1'b1;
        s.want  = '{row: ROW_W'(row), column: '0, pixel: b, run_last: 1'b1,
                    image_last: 1'b0};
        return s;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint exp);
        if (mismatches < 100)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t ns",
                     field, got, exp, $time);
        mismatches++;
    endtask

    task automatic decode_byte(input logic [DATA_W-1:0] b);
        int   n;
        int   k;
        int   planes;
        int   width;
        bit   line_end;
        bit   img_end;
        bit   have;
        pix_t cur;
        if (image_done || pos_row >= cfg_rows)
            return;
        if (value_due) begin
            value_due = 1'b0;
            n = int'(run_len);
        end else if (cfg_rle && (b & COUNT_MASK) == COUNT_MASK) begin
            run_len   = b[CNT_W-1:0];
            value_due = 1'b1;
            return;
        end else begin
            n = 1;
        end
        planes = (cfg_planes == 0) ? 1 : (cfg_planes > MAX_PLANES) ? MAX_PLANES
                                                                   : int'(cfg_planes);
        width  = (cfg_bpl == 0) ? 1 : int'(cfg_bpl);
        have   = 1'b0;
        cur    = '0;
        for (k = 0; k < n; k++) begin
            line_end = (int'(pos_byte) + 1 >= width) && (int'(pos_plane) + 1 >= planes);
            img_end  = line_end && (int'(pos_row) + 1 >= int'(cfg_rows));
            if (have)
                decoded.push_back(cur);
            cur.row        = pos_row;
            cur.column     = COL_W'(int'(pos_byte) * planes + int'(pos_plane));
            cur.pixel      = b;
            cur.run_last   = 1'b0;
            cur.image_last = img_end;
            have = 1'b1;
            if (int'(pos_byte) + 1 >= width) begin
                pos_byte = '0;
                if (int'(pos_plane) + 1 >= planes) begin
                    pos_plane = '0;
                    pos_row   = pos_row + 1'b1;
                    if (img_end)
                        image_done = 1'b1;
                end else begin
                    pos_plane = pos_plane + 1'b1;
                end
            end else begin
                pos_byte = pos_byte + 1'b1;
            end
            if (line_end)
                break;
        end
        if (have) begin
            cur.run_last = 1'b1;
            decoded.push_back(cur);
        end
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RLE_ENABLED:    cfg_rle    = val[0];
            REG_BYTES_PER_LINE: cfg_bpl    = val[BPL_W-1:0];
            REG_PLANE_COUNT:    cfg_planes = val[PC_W-1:0];
            REG_IMAGE_ROWS:     cfg_rows   = val[ROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic feed_byte(input logic [DATA_W-1:0] b, input bit typed,
                             input pix_t want);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decoded.delete();
        decode_byte(b);
        if (typed)
            pixels_due.push_back(want);
        else
            foreach (decoded[i]) pixels_due.push_back(decoded[i]);
    endtask

    // hold the input until every expected word is out and the block is quiet
    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_bytes(input int items);
        int sent;
        int pick;
        logic [DATA_W-1:0] b;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                feed_byte({2'b11, CNT_W'($urandom_range(0, 63))}, 1'b0, '0);
                feed_byte(DATA_W'($urandom_range(0, 255)), 1'b0, '0);
                sent += 2;
            end else if (pick <= 8) begin
                b = cfg_rle ? DATA_W'($urandom_range(0, 191))
                            : DATA_W'($urandom_range(0, 255));
                feed_byte(b, 1'b0, '0);
                sent++;
            end else begin
                feed_byte(DATA_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver stall pattern, chosen at random among four modes and reselected
    always @(posedge aclk) begin
        if (ready_tick % 50 == 0)
            ready_mode <= $urandom_range(0, 3);
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (ready_tick % 4 == 0);
            default: m_ready <= ((ready_tick / 16) % 2 == 1);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected word", m_pixel_byte, 0);
            end else begin
                head = pixels_due.pop_front();
                if (m_row !== head.row)
                    report_mismatch("row", m_row, head.row);
                if (m_column !== head.column)
                    report_mismatch("column", m_column, head.column);
                if (m_pixel_byte !== head.pixel)
                    report_mismatch("pixel_byte", m_pixel_byte, head.pixel);
                if (m_run_last !== head.run_last)
                    report_mismatch("run_last", m_run_last, head.run_last);
                if (m_image_last !== head.image_last)
                    report_mismatch("image_last", m_image_last, head.image_last);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int p;
        int guard;
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back(reg_step(REG_IMAGE_ROWS, 32'hFFFF));
        plan.push_back(pix_step(8'h00, 0));
        plan.push_back(pix_step(8'hBF, 1));
        plan.push_back(pix_step(8'h7F, 2));
        plan.push_back(byte_step(8'hC3));
        plan.push_back(pix_step(8'hFF, 3));            // run cut at line end
        plan.push_back(reg_step(REG_BYTES_PER_LINE, 4));
        plan.push_back(reg_step(REG_PLANE_COUNT, 3));
        plan.push_back(byte_step(8'hC5));
        plan.push_back(byte_step(8'h5A));
        plan.push_back(byte_step(8'hC0));              // zero count
        plan.push_back(byte_step(8'h33));
        plan.push_back(byte_step(8'hFF));
        plan.push_back(byte_step(8'hA5));
        plan.push_back(reg_step(REG_RLE_ENABLED, 0));
        plan.push_back(byte_step(8'hC2));
        plan.push_back(byte_step(8'hFF));
        plan.push_back(reg_step(REG_RLE_ENABLED, 1));
        plan.push_back(byte_step(8'hC4));
        plan.push_back(reg_step(REG_RLE_ENABLED, 0));  // value still owed
        plan.push_back(byte_step(8'hC1));
        plan.push_back(reg_step(REG_RLE_ENABLED, 1));
        plan.push_back(reg_step(REG_PLANE_COUNT, 7));
        plan.push_back(reg_step(REG_BYTES_PER_LINE, 0));
        plan.push_back(byte_step(8'h11));
        plan.push_back(byte_step(8'hC6));
        plan.push_back(byte_step(8'h22));
        plan.push_back(reg_step(REG_PLANE_COUNT, 0));
        plan.push_back(reg_step(REG_BYTES_PER_LINE, 32'hFFFF));
        plan.push_back(byte_step(8'hFF));
        plan.push_back(byte_step(8'h00));
        plan.push_back(byte_step(8'h80));
        plan.push_back(reg_step(REG_IMAGE_ROWS, 3));   // rows already past the image
        plan.push_back(byte_step(8'h44));
        plan.push_back(byte_step(8'hC2));
        plan.push_back(reg_step(REG_IMAGE_ROWS, 0));
        plan.push_back(byte_step(8'h01));
        plan.push_back(reg_step(REG_IMAGE_ROWS, 32'hFFFF));
        plan.push_back(reg_step(REG_PLANE_COUNT, 4));
        plan.push_back(reg_step(REG_BYTES_PER_LINE, 2));
        plan.push_back(byte_step(8'h3C));

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                drain_pixels();
                reg_write(plan[i].idx, plan[i].val);
            end else begin
                feed_byte(plan[i].val[DATA_W-1:0], plan[i].typed, plan[i].want);
            end
        end

        for (p = 0; p < 4; p++) begin
            drain_pixels();
            reg_write(REG_RLE_ENABLED, 32'(p != 2));
            case ($urandom_range(0, 5))
                0:       reg_write(REG_BYTES_PER_LINE, 0);
                5:       reg_write(REG_BYTES_PER_LINE, $urandom_range(9, 65535));
                default: reg_write(REG_BYTES_PER_LINE, $urandom_range(1, 8));
            endcase
            reg_write(REG_PLANE_COUNT, $urandom_range(0, 7));
            reg_write(REG_IMAGE_ROWS, 32'hFFFF);
            random_bytes(12);
            drain_pixels();
            random_bytes(12);
        end

        // close the image two rows on, then bytes past its end
        drain_pixels();
        reg_write(REG_RLE_ENABLED, 1);
        reg_write(REG_BYTES_PER_LINE, 3);
        reg_write(REG_PLANE_COUNT, 2);
        reg_write(REG_IMAGE_ROWS, 32'(pos_row) + 32'd2);
        guard = 0;
        while (!image_done && guard < 20) begin
            feed_byte(8'hFF, 1'b0, '0);
            feed_byte(DATA_W'($urandom_range(0, 255)), 1'b0, '0);
            guard++;
        end
        feed_byte(8'h12, 1'b0, '0);
        feed_byte(8'hC5, 1'b0, '0);
        feed_byte(8'h34, 1'b0, '0);
        drain_pixels();

        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* pcx_rle_scanline_decoder.f */
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_regs.sv
rtl/core/pcxrle_ctrl.sv
rtl/core/pcxrle_dp.sv
rtl/core/pcx_rle_scanline_decoder.sv
sim/tb_pcx_rle_scanline_decoder.sv
